// File: src/pfm_pkg.sv
package pfm_pkg;

    localparam int LIMBS = 5;
    localparam int IN_W = 53;
    localparam int LIMB_W = 51;
    localparam int P1_W = 52;

    // Operands are split into a 27-bit low half and a 26-bit high half.
    localparam int LO_W = 27;
    localparam int HI_W = IN_W - LO_W;

    localparam int PROD_W = 2 * IN_W;
    localparam int LOW_SUM_W = PROD_W + 3;
    localparam int HIGH_SUM_W = PROD_W + 2;
    localparam int COL_W = PROD_W + 8;
    localparam int CARRY_W = COL_W - LIMB_W;
    localparam int FOLD_W = 64;

    localparam int STAGES = 7;

    localparam logic [4:0] FOLD = 5'd19;

    typedef logic [IN_W-1:0] in_limb_t;
    typedef logic [LIMB_W-1:0] limb_t;
    typedef logic [P1_W-1:0] limb1_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [CARRY_W-1:0] carry_t;

endpackage

// File: src/pfm_if.sv
interface pfm_in_if;
    logic valid;
    logic ready;
    pfm_pkg::in_limb_t a_limb0;
    pfm_pkg::in_limb_t a_limb1;
    pfm_pkg::in_limb_t a_limb2;
    pfm_pkg::in_limb_t a_limb3;
    pfm_pkg::in_limb_t a_limb4;
    pfm_pkg::in_limb_t b_limb0;
    pfm_pkg::in_limb_t b_limb1;
    pfm_pkg::in_limb_t b_limb2;
    pfm_pkg::in_limb_t b_limb3;
    pfm_pkg::in_limb_t b_limb4;

    modport source (
        output valid, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
        output b_limb0, b_limb1, b_limb2, b_limb3, b_limb4,
        input ready
    );
    modport sink (
        input valid, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
        input b_limb0, b_limb1, b_limb2, b_limb3, b_limb4,
        output ready
    );
endinterface

interface pfm_out_if;
    logic valid;
    logic ready;
    pfm_pkg::limb_t p_limb0;
    pfm_pkg::limb1_t p_limb1;
    pfm_pkg::limb_t p_limb2;
    pfm_pkg::limb_t p_limb3;
    pfm_pkg::limb_t p_limb4;

    modport source (
        output valid, p_limb0, p_limb1, p_limb2, p_limb3, p_limb4,
        input ready
    );
    modport sink (
        input valid, p_limb0, p_limb1, p_limb2, p_limb3, p_limb4,
        output ready
    );
endinterface

// File: src/p25519_field_multiply.sv
// Field multiplier for GF(2^255-19) with operands in radix 2^51.
//
// The operands channel carries one word per product: two operands of five
// 53-bit limbs each. The product channel returns one word of five limbs,
// congruent to a*b modulo 2^255-19 but only partially reduced. Squaring is
// done by sending the same limbs on both operands.
//
// A new word may enter in every cycle while the product channel keeps up, so
// throughput is one product per cycle when the receiver does not stall.
// The 7 stages are: 27x27 partial products, full 106-bit limb products,
// column sums, fold of the high columns by 19, two carry stages and the
// final fold of the top carry into limbs 0 and 1.
//
// Each stage holds a valid bit. When the receiver stalls, the product word
// holds in the last stage and earlier stages keep filling until each holds a
// word; only then does operands.ready drop. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is then empty and ready.
module p25519_field_multiply (
    input logic clk,
    input logic rst_n,
    pfm_in_if.sink operands,
    pfm_out_if.source product
);

    // Stage control.
    logic [pfm_pkg::STAGES:1] valid_reg;
    logic [pfm_pkg::STAGES:1] en;

    always_comb
    begin
        en[pfm_pkg::STAGES] = !valid_reg[pfm_pkg::STAGES] || product.ready;
        for (int k = pfm_pkg::STAGES - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= operands.valid;
            end
            for (int k = 2; k <= pfm_pkg::STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    assign operands.ready = en[1];

    // Stage 1: four half-width partial products per limb pair.
    pfm_pkg::in_limb_t a [pfm_pkg::LIMBS];
    pfm_pkg::in_limb_t b [pfm_pkg::LIMBS];

    assign a[0] = operands.a_limb0;
    assign a[1] = operands.a_limb1;
    assign a[2] = operands.a_limb2;
    assign a[3] = operands.a_limb3;
    assign a[4] = operands.a_limb4;
    assign b[0] = operands.b_limb0;
    assign b[1] = operands.b_limb1;
    assign b[2] = operands.b_limb2;
    assign b[3] = operands.b_limb3;
    assign b[4] = operands.b_limb4;

    logic [2*pfm_pkg::LO_W-1:0] pp_ll_reg [pfm_pkg::LIMBS][pfm_pkg::LIMBS];
    logic [pfm_pkg::IN_W-1:0] pp_lh_reg [pfm_pkg::LIMBS][pfm_pkg::LIMBS];
    logic [pfm_pkg::IN_W-1:0] pp_hl_reg [pfm_pkg::LIMBS][pfm_pkg::LIMBS];
    logic [2*pfm_pkg::HI_W-1:0] pp_hh_reg [pfm_pkg::LIMBS][pfm_pkg::LIMBS];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < pfm_pkg::LIMBS; i++)
            begin
                for (int j = 0; j < pfm_pkg::LIMBS; j++)
                begin
                    pp_ll_reg[i][j] <= (2*pfm_pkg::LO_W)'(a[i][pfm_pkg::LO_W-1:0])
                        * (2*pfm_pkg::LO_W)'(b[j][pfm_pkg::LO_W-1:0]);
                    pp_lh_reg[i][j] <= pfm_pkg::IN_W'(a[i][pfm_pkg::LO_W-1:0])
                        * pfm_pkg::IN_W'(b[j][pfm_pkg::IN_W-1:pfm_pkg::LO_W]);
                    pp_hl_reg[i][j] <= pfm_pkg::IN_W'(a[i][pfm_pkg::IN_W-1:pfm_pkg::LO_W])
                        * pfm_pkg::IN_W'(b[j][pfm_pkg::LO_W-1:0]);
                    pp_hh_reg[i][j] <= (2*pfm_pkg::HI_W)'(a[i][pfm_pkg::IN_W-1:pfm_pkg::LO_W])
                        * (2*pfm_pkg::HI_W)'(b[j][pfm_pkg::IN_W-1:pfm_pkg::LO_W]);
                end
            end
        end
    end

    // Stage 2: recombine the partial products into full limb products.
    pfm_pkg::prod_t prod_reg [pfm_pkg::LIMBS][pfm_pkg::LIMBS];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < pfm_pkg::LIMBS; i++)
            begin
                for (int j = 0; j < pfm_pkg::LIMBS; j++)
                begin
                    prod_reg[i][j] <= pfm_pkg::PROD_W'(pp_ll_reg[i][j])
                        + (pfm_pkg::PROD_W'(pp_lh_reg[i][j]) << pfm_pkg::LO_W)
                        + (pfm_pkg::PROD_W'(pp_hl_reg[i][j]) << pfm_pkg::LO_W)
                        + (pfm_pkg::PROD_W'(pp_hh_reg[i][j]) << (2*pfm_pkg::LO_W));
                end
            end
        end
    end

    // Stage 3: column sums. Columns at weight 2^255 and above are kept apart
    // so that the fold by 19 is applied once per column.
    logic [pfm_pkg::LOW_SUM_W-1:0] low_next [pfm_pkg::LIMBS];
    logic [pfm_pkg::HIGH_SUM_W-1:0] high_next [pfm_pkg::LIMBS];
    logic [pfm_pkg::LOW_SUM_W-1:0] low_reg [pfm_pkg::LIMBS];
    logic [pfm_pkg::HIGH_SUM_W-1:0] high_reg [pfm_pkg::LIMBS];

    always_comb
    begin
        for (int k = 0; k < pfm_pkg::LIMBS; k++)
        begin
            low_next[k] = '0;
            high_next[k] = '0;
        end
        for (int i = 0; i < pfm_pkg::LIMBS; i++)
        begin
            for (int j = 0; j < pfm_pkg::LIMBS; j++)
            begin
                if (i + j < pfm_pkg::LIMBS)
                begin
                    low_next[i + j] = low_next[i + j]
                        + pfm_pkg::LOW_SUM_W'(prod_reg[i][j]);
                end
                else
                begin
                    high_next[i + j - pfm_pkg::LIMBS] = high_next[i + j - pfm_pkg::LIMBS]
                        + pfm_pkg::HIGH_SUM_W'(prod_reg[i][j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            low_reg <= low_next;
            high_reg <= high_next;
        end
    end

    // Stage 4: fold the high columns back by 19 = 16 + 2 + 1.
    pfm_pkg::col_t col_reg [pfm_pkg::LIMBS];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int k = 0; k < pfm_pkg::LIMBS; k++)
            begin
                col_reg[k] <= pfm_pkg::COL_W'(low_reg[k])
                    + (pfm_pkg::COL_W'(high_reg[k]) << 4)
                    + (pfm_pkg::COL_W'(high_reg[k]) << 1)
                    + pfm_pkg::COL_W'(high_reg[k]);
            end
        end
    end

    // Stage 5: carry from column 0 into 1 and from 1 into 2.
    pfm_pkg::col_t c1_s5;
    pfm_pkg::limb_t c0_lo_s5_reg;
    pfm_pkg::limb_t c1_lo_s5_reg;
    pfm_pkg::col_t c2_s5_reg;
    pfm_pkg::col_t c3_s5_reg;
    pfm_pkg::col_t c4_s5_reg;

    assign c1_s5 = col_reg[1]
        + pfm_pkg::COL_W'(col_reg[0][pfm_pkg::COL_W-1:pfm_pkg::LIMB_W]);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            c0_lo_s5_reg <= col_reg[0][pfm_pkg::LIMB_W-1:0];
            c1_lo_s5_reg <= c1_s5[pfm_pkg::LIMB_W-1:0];
            c2_s5_reg <= col_reg[2]
                + pfm_pkg::COL_W'(c1_s5[pfm_pkg::COL_W-1:pfm_pkg::LIMB_W]);
            c3_s5_reg <= col_reg[3];
            c4_s5_reg <= col_reg[4];
        end
    end

    // Stage 6: carry from column 2 into 3 and from 3 into 4.
    pfm_pkg::col_t c3_s6;
    pfm_pkg::col_t c4_s6;
    pfm_pkg::limb_t c0_lo_s6_reg;
    pfm_pkg::limb_t c1_lo_s6_reg;
    pfm_pkg::limb_t c2_lo_s6_reg;
    pfm_pkg::limb_t c3_lo_s6_reg;
    pfm_pkg::limb_t c4_lo_s6_reg;
    pfm_pkg::carry_t top_carry_reg;

    assign c3_s6 = c3_s5_reg
        + pfm_pkg::COL_W'(c2_s5_reg[pfm_pkg::COL_W-1:pfm_pkg::LIMB_W]);
    assign c4_s6 = c4_s5_reg
        + pfm_pkg::COL_W'(c3_s6[pfm_pkg::COL_W-1:pfm_pkg::LIMB_W]);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            c0_lo_s6_reg <= c0_lo_s5_reg;
            c1_lo_s6_reg <= c1_lo_s5_reg;
            c2_lo_s6_reg <= c2_s5_reg[pfm_pkg::LIMB_W-1:0];
            c3_lo_s6_reg <= c3_s6[pfm_pkg::LIMB_W-1:0];
            c4_lo_s6_reg <= c4_s6[pfm_pkg::LIMB_W-1:0];
            top_carry_reg <= c4_s6[pfm_pkg::COL_W-1:pfm_pkg::LIMB_W];
        end
    end

    // Stage 7: fold the carry out of limb 4 by 19 = 16 + 2 + 1 into limb 0,
    // kept at 64 bits, and pass the carry of that sum into limb 1.
    logic [pfm_pkg::FOLD_W-1:0] fold_prod;
    logic [pfm_pkg::FOLD_W-1:0] low0;
    pfm_pkg::limb_t p0_reg;
    pfm_pkg::limb1_t p1_reg;
    pfm_pkg::limb_t p2_reg;
    pfm_pkg::limb_t p3_reg;
    pfm_pkg::limb_t p4_reg;

    assign fold_prod = (pfm_pkg::FOLD_W'(top_carry_reg) << 4)
        + (pfm_pkg::FOLD_W'(top_carry_reg) << 1)
        + pfm_pkg::FOLD_W'(top_carry_reg);
    assign low0 = pfm_pkg::FOLD_W'(c0_lo_s6_reg) + fold_prod;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            p0_reg <= low0[pfm_pkg::LIMB_W-1:0];
            p1_reg <= pfm_pkg::P1_W'(c1_lo_s6_reg)
                + pfm_pkg::P1_W'(low0[pfm_pkg::FOLD_W-1:pfm_pkg::LIMB_W]);
            p2_reg <= c2_lo_s6_reg;
            p3_reg <= c3_lo_s6_reg;
            p4_reg <= c4_lo_s6_reg;
        end
    end

    assign product.valid = valid_reg[pfm_pkg::STAGES];
    assign product.p_limb0 = p0_reg;
    assign product.p_limb1 = p1_reg;
    assign product.p_limb2 = p2_reg;
    assign product.p_limb3 = p3_reg;
    assign product.p_limb4 = p4_reg;

endmodule

// File: bench/tb_p25519_field_multiply.sv
`timescale 1ns / 100ps

module tb_p25519_field_multiply;

    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam pfm_pkg::in_limb_t LIMB_MAX = {pfm_pkg::IN_W{1'b1}};
    localparam pfm_pkg::in_limb_t RADIX_MAX = pfm_pkg::in_limb_t'({pfm_pkg::LIMB_W{1'b1}});
    localparam pfm_pkg::in_limb_t PRIME_LIMB0 = RADIX_MAX - pfm_pkg::in_limb_t'(18);
    localparam pfm_pkg::in_limb_t TOP_BIT = pfm_pkg::in_limb_t'(1) << (pfm_pkg::IN_W - 1);

    typedef struct {
        pfm_pkg::in_limb_t a[pfm_pkg::LIMBS];
        pfm_pkg::in_limb_t b[pfm_pkg::LIMBS];
    } operands_t;

    typedef struct packed {
        pfm_pkg::limb_t p0;
        pfm_pkg::limb1_t p1;
        pfm_pkg::limb_t p2;
        pfm_pkg::limb_t p3;
        pfm_pkg::limb_t p4;
    } product_t;

    // Keeps the products still owed by the multiplier, oldest first.
    class product_ledger;
        product_t owed[$];
        int failures;

        function new();
            failures = 0;
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            failures++;
        endtask

        function int outstanding();
            return owed.size();
        endfunction

        // Schoolbook product with the high columns folded by 19, one carry
        // pass, then the top carry folded into limbs 0 and 1.
        function product_t field_product(input operands_t w);
            logic [127:0] col[pfm_pkg::LIMBS];
            logic [63:0] carry;
            logic [63:0] low0;
            product_t p;
            for (int k = 0; k < pfm_pkg::LIMBS; k++)
                col[k] = '0;
            for (int i = 0; i < pfm_pkg::LIMBS; i++)
            begin
                for (int j = 0; j < pfm_pkg::LIMBS; j++)
                begin
                    if (i + j < pfm_pkg::LIMBS)
                        col[i + j] += 128'(w.a[i]) * 128'(w.b[j]);
                    else
                        col[i + j - pfm_pkg::LIMBS] += 128'(w.a[i]) * 128'(pfm_pkg::FOLD)
                            * 128'(w.b[j]);
                end
            end
            for (int k = 1; k < pfm_pkg::LIMBS; k++)
            begin
                carry = 64'(col[k - 1] >> pfm_pkg::LIMB_W);
                col[k] += 128'(carry);
            end
            carry = 64'(col[pfm_pkg::LIMBS - 1] >> pfm_pkg::LIMB_W);
            low0 = 64'(col[0][pfm_pkg::LIMB_W-1:0]) + 64'(pfm_pkg::FOLD) * carry;
            p.p0 = low0[pfm_pkg::LIMB_W-1:0];
            p.p1 = pfm_pkg::limb1_t'(col[1][pfm_pkg::LIMB_W-1:0])
                + pfm_pkg::limb1_t'(low0 >> pfm_pkg::LIMB_W);
            p.p2 = col[2][pfm_pkg::LIMB_W-1:0];
            p.p3 = col[3][pfm_pkg::LIMB_W-1:0];
            p.p4 = col[4][pfm_pkg::LIMB_W-1:0];
            return p;
        endfunction

        function void note_operands(input operands_t w);
            owed.push_back(field_product(w));
        endfunction

        task check_product(input product_t got);
            product_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("product word with none owed: %h", got));
                return;
            end
            want = owed.pop_front();
            if (got.p0 !== want.p0)
                report($sformatf("p_limb0 got %h want %h", got.p0, want.p0));
            if (got.p1 !== want.p1)
                report($sformatf("p_limb1 got %h want %h", got.p1, want.p1));
            if (got.p2 !== want.p2)
                report($sformatf("p_limb2 got %h want %h", got.p2, want.p2));
            if (got.p3 !== want.p3)
                report($sformatf("p_limb3 got %h want %h", got.p3, want.p3));
            if (got.p4 !== want.p4)
                report($sformatf("p_limb4 got %h want %h", got.p4, want.p4));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_product;
    int hold_count;
    int quiet_cycles;
    product_ledger ledger = new();

    pfm_in_if operands_if();
    pfm_out_if product_if();

    p25519_field_multiply dut (
        .clk(clk),
        .rst_n(rst_n),
        .operands(operands_if),
        .product(product_if)
    );

    always #4 clk = ~clk;

    // Receiver: random back-pressure, or one long hold-off when asked.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_product)
            begin
                product_if.ready <= 1'b0;
                hold_count++;
                if (hold_count == HOLD_CYCLES)
                begin
                    hold_count = 0;
                    hold_product = 1'b0;
                end
            end
            else
                product_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Both channels are sampled here, and the watchdog counts idle cycles.
    always @(posedge clk)
    begin : monitor
        operands_t w;
        product_t got;
        bit moved;
        moved = 1'b0;
        if (rst_n && operands_if.valid && operands_if.ready)
        begin
            w.a[0] = operands_if.a_limb0;
            w.a[1] = operands_if.a_limb1;
            w.a[2] = operands_if.a_limb2;
            w.a[3] = operands_if.a_limb3;
            w.a[4] = operands_if.a_limb4;
            w.b[0] = operands_if.b_limb0;
            w.b[1] = operands_if.b_limb1;
            w.b[2] = operands_if.b_limb2;
            w.b[3] = operands_if.b_limb3;
            w.b[4] = operands_if.b_limb4;
            ledger.note_operands(w);
            moved = 1'b1;
        end
        if (rst_n && product_if.valid && product_if.ready)
        begin
            got.p0 = product_if.p_limb0;
            got.p1 = product_if.p_limb1;
            got.p2 = product_if.p_limb2;
            got.p3 = product_if.p_limb3;
            got.p4 = product_if.p_limb4;
            ledger.check_product(got);
            moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_p25519_field_multiply: FAIL");
            $finish;
        end
    end

    function automatic pfm_pkg::in_limb_t rand_limb();
        pfm_pkg::in_limb_t v;
        v = pfm_pkg::in_limb_t'({$urandom, $urandom});
        case ($urandom_range(9))
            0: v = '0;
            1: v = LIMB_MAX;
            2: v = v & RADIX_MAX;
            3: v = pfm_pkg::in_limb_t'(1) << $urandom_range(pfm_pkg::IN_W - 1);
            4: v = LIMB_MAX - pfm_pkg::in_limb_t'($urandom_range(31));
            5: v = RADIX_MAX - pfm_pkg::in_limb_t'($urandom_range(31));
            default: ;
        endcase
        return v;
    endfunction

    // One in four random words is a square, as the squaring path uses.
    function automatic operands_t rand_operands();
        operands_t w;
        bit square;
        square = ($urandom_range(3) == 0);
        for (int i = 0; i < pfm_pkg::LIMBS; i++)
        begin
            w.a[i] = rand_limb();
            w.b[i] = square ? w.a[i] : rand_limb();
        end
        return w;
    endfunction

    function automatic operands_t uniform_operands(input pfm_pkg::in_limb_t av,
                                                   input pfm_pkg::in_limb_t bv);
        operands_t w;
        for (int i = 0; i < pfm_pkg::LIMBS; i++)
        begin
            w.a[i] = av;
            w.b[i] = bv;
        end
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_operands(input operands_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            operands_if.valid <= 1'b0;
            @(negedge clk);
        end
        operands_if.valid <= 1'b1;
        operands_if.a_limb0 <= w.a[0];
        operands_if.a_limb1 <= w.a[1];
        operands_if.a_limb2 <= w.a[2];
        operands_if.a_limb3 <= w.a[3];
        operands_if.a_limb4 <= w.a[4];
        operands_if.b_limb0 <= w.b[0];
        operands_if.b_limb1 <= w.b[1];
        operands_if.b_limb2 <= w.b[2];
        operands_if.b_limb3 <= w.b[3];
        operands_if.b_limb4 <= w.b[4];
        do
            @(posedge clk);
        while (!operands_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_all_products();
        operands_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (ledger.outstanding() != 0);
    endtask

    task automatic send_directed();
        operands_t w;
        send_operands(uniform_operands('0, '0));
        send_operands(uniform_operands(LIMB_MAX, LIMB_MAX));
        send_operands(uniform_operands(LIMB_MAX, '0));
        send_operands(uniform_operands('0, LIMB_MAX));
        send_operands(uniform_operands(TOP_BIT, LIMB_MAX));
        send_operands(uniform_operands(RADIX_MAX, RADIX_MAX));
        // The prime itself, times the largest operand and squared.
        w = uniform_operands(RADIX_MAX, LIMB_MAX);
        w.a[0] = PRIME_LIMB0;
        send_operands(w);
        w.b = w.a;
        send_operands(w);
        w = uniform_operands('0, '0);
        w.a[0] = pfm_pkg::in_limb_t'(1);
        w.b[0] = pfm_pkg::in_limb_t'(1);
        send_operands(w);
        // Only the top limbs set, so every term goes through the fold.
        w = uniform_operands('0, '0);
        w.a[4] = LIMB_MAX;
        w.b[4] = LIMB_MAX;
        send_operands(w);
        w.a[1] = LIMB_MAX;
        w.b[3] = LIMB_MAX;
        send_operands(w);
        w = uniform_operands(LIMB_MAX, '0);
        w.b[0] = pfm_pkg::in_limb_t'(1);
        send_operands(w);
        send_operands(uniform_operands(pfm_pkg::in_limb_t'(53'h0AAAAAAAAAAAAA),
                                       pfm_pkg::in_limb_t'(53'h15555555555555)));
        send_operands(uniform_operands(pfm_pkg::in_limb_t'(53'h15555555555555),
                                       pfm_pkg::in_limb_t'(53'h15555555555555)));
        for (int n = 0; n < 6; n++)
        begin
            for (int i = 0; i < pfm_pkg::LIMBS; i++)
            begin
                w.a[i] = pfm_pkg::in_limb_t'({$urandom, $urandom});
                w.b[i] = w.a[i];
            end
            send_operands(w);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        quiet_cycles = 0;
        hold_product = 1'b0;
        hold_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        operands_if.valid = 1'b0;
        operands_if.a_limb0 = '0;
        operands_if.a_limb1 = '0;
        operands_if.a_limb2 = '0;
        operands_if.a_limb3 = '0;
        operands_if.a_limb4 = '0;
        operands_if.b_limb0 = '0;
        operands_if.b_limb1 = '0;
        operands_if.b_limb2 = '0;
        operands_if.b_limb3 = '0;
        operands_if.b_limb4 = '0;
        product_if.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_directed();
        wait_all_products();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 57 : 0;
            rx_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 24 : 0;
            for (int n = 0; n < RANDOM_WORDS / 3; n++)
            begin
                // The sender keeps offering while the receiver holds off, so
                // the pipeline fills and the operand port must stall.
                if (phase == 0 && n == 100)
                    hold_product = 1'b1;
                send_operands(rand_operands());
            end
            wait_all_products();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.outstanding() != 0)
            ledger.report($sformatf("%0d product words never came", ledger.outstanding()));
        if (ledger.failures == 0)
            $display("tb_p25519_field_multiply: PASS");
        else
            $display("tb_p25519_field_multiply: FAIL");
        $finish;
    end

endmodule

// File: files.f
src/pfm_pkg.sv
src/pfm_if.sv
src/p25519_field_multiply.sv
bench/tb_p25519_field_multiply.sv
